@@ rtl/core/uvs_pkg.sv @@
`default_nettype none
package uvs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEL_W     = 24;
    localparam int VAR_W     = 23;
    localparam int COV_W     = 24;
    localparam int BUF_W     = 23;
    localparam logic [BUF_W-1:0] BUF_RESET = 23'd19661;

    // Velocity magnitudes are scaled down below 2^NORM_W for the projection.
    localparam int NORM_W  = 15;
    localparam int SQ_W    = 2 * NORM_W;
    localparam int DEN_W   = SQ_W + 1;
    localparam int NUM_W   = 56;
    // The projected variance always stays below 2^QUO_W.
    localparam int QUO_W   = 25;
    localparam int SPD_W   = 25;
    localparam int DEV_W   = (QUO_W + FRAC_BITS + 1) / 2;
    localparam int GAIN_W  = FRAC_BITS + 1;
    localparam int GREM_W  = DEV_W + 1;
    localparam int PROD_W  = VEL_W + GAIN_W;

    localparam int TDATA_IN_W  = 120;
    localparam int TDATA_OUT_W = 48;

    typedef enum logic [1:0] {
        VERDICT_ZERO    = 2'd0,
        VERDICT_TRUSTED = 2'd1,
        VERDICT_GAIN    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic signed [VEL_W-1:0]      vx;
        logic signed [VEL_W-1:0]      vy;
        logic [VAR_W-1:0]             sxx;
        logic [VAR_W-1:0]             syy;
        logic signed [COV_W-1:0]      sxy;
        logic [VEL_W-1:0]             ax;
        logic [VEL_W-1:0]             ay;
        logic [NORM_W-1:0]            axs;
        logic [NORM_W-1:0]            ays;
        logic                         zero;
        logic                         opp;
        logic [2*VEL_W-1:0]           sqx;
        logic [2*VEL_W-1:0]           sqy;
        logic [2*VEL_W:0]             ssum;
        logic [SQ_W-1:0]              a;
        logic [SQ_W-1:0]              b;
        logic [SQ_W-1:0]              c;
        logic [SQ_W+VAR_W-1:0]        pa;
        logic [SQ_W+VAR_W-1:0]        pb;
        logic signed [SQ_W+COV_W-1:0] pc;
        logic [DEN_W-1:0]             den;
        logic [QUO_W-1:0]             dnum;
        logic [DEN_W-1:0]             drem;
        logic [QUO_W-1:0]             dq;
        logic [2*SPD_W-1:0]           sn;
        logic [SPD_W+1:0]             srem;
        logic [SPD_W-1:0]             sroot;
        logic [2*DEV_W-1:0]           tn;
        logic [DEV_W+1:0]             trem;
        logic [DEV_W-1:0]             troot;
        logic signed [VEL_W-1:0]      limit;
        logic                         trusted;
        logic                         gz;
        logic                         gf;
        logic [GREM_W-1:0]            grem;
        logic [FRAC_BITS-1:0]         gq;
        logic [GAIN_W-1:0]            gain;
        logic [PROD_W-1:0]            px;
        logic [PROD_W-1:0]            py;
        logic signed [VEL_W-1:0]      ovx;
        logic signed [VEL_W-1:0]      ovy;
        verdict_t                     verdict;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/core/uncertain_velocity_suppressor.sv @@
`default_nettype none
// Uncertain-velocity suppressor. Each input item carries a planar velocity and its 2x2
// covariance; each output item carries the velocity, scaled down when the standard
// deviation of the velocity along its own direction, less the configured
// uncertainty_buffer, is large compared with the speed. The datapath is a 72-stage
// pipeline that accepts one item every clock cycle while the output is not stalled. Most
// of its depth is taken by the three bit-serial units laid out as stages: the 25-stage
// projected-variance divider (run beside the 25-stage speed square root), the 21-stage
// standard-deviation square root and the 16-stage gain divider. The whole pipeline holds
// while a result waits on m_tready, so nothing is lost or repeated. uncertainty_buffer is
// written through the cfg channel, which is always ready, and must only be changed while
// no item is in flight.
module uncertain_velocity_suppressor
    import uvs_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // vel_x[23:0], vel_y[47:24], var_xx[70:48], var_yy[93:71], covar_xy[117:94], zero pad.
    input  wire [TDATA_IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // out_vel_x[23:0], out_vel_y[47:24].
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // verdict[1:0].
    output logic [1:0]             m_tuser,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [BUF_W-1:0]        cfg_data
);

    localparam int ST_IN    = 0;
    localparam int ST_ABS   = 1;
    localparam int ST_MUL1  = 2;
    localparam int ST_MUL2  = 3;
    localparam int ST_NUM   = 4;
    localparam int ST_D0    = 5;
    localparam int ST_TINIT = ST_D0 + QUO_W;
    localparam int ST_T0    = ST_TINIT + 1;
    localparam int ST_LIM   = ST_T0 + DEV_W;
    localparam int ST_G0    = ST_LIM + 1;
    localparam int ST_GSEL  = ST_G0 + FRAC_BITS;
    localparam int ST_SCL   = ST_GSEL + 1;
    localparam int ST_OUT   = ST_SCL + 1;
    localparam int NST      = ST_OUT + 1;

    item_t            pipe_reg [NST];
    item_t            pipe_next [NST];
    logic [NST-1:0]   vld_reg;
    logic [BUF_W-1:0] buf_reg;
    logic             adv;

    // Scale both magnitudes down by one common shift so that the larger one fits NORM_W bits.
    function automatic item_t f_abs(input item_t p);
        item_t            r;
        logic [VEL_W-1:0] m;
        logic [4:0]       blen;
        logic [4:0]       k;
        r = p;
        r.ax = p.vx[VEL_W-1] ? VEL_W'(-p.vx) : VEL_W'(p.vx);
        r.ay = p.vy[VEL_W-1] ? VEL_W'(-p.vy) : VEL_W'(p.vy);
        r.zero = (r.ax == '0) && (r.ay == '0);
        r.opp = p.vx[VEL_W-1] != p.vy[VEL_W-1];
        m = (r.ax > r.ay) ? r.ax : r.ay;
        blen = '0;
        for (int i = 0; i < VEL_W; i++) begin
            if (m[i]) begin
                blen = 5'(i + 1);
            end
        end
        k = (blen > 5'(NORM_W)) ? 5'(blen - 5'(NORM_W)) : '0;
        r.axs = NORM_W'(r.ax >> k);
        r.ays = NORM_W'(r.ay >> k);
        return r;
    endfunction

    // One remainder step of the speed square root, two radicand bits at a time.
    function automatic item_t f_spd_step(input item_t p);
        item_t            r;
        logic [SPD_W+3:0] t;
        logic [SPD_W+3:0] trial;
        r = p;
        t = {p.srem, p.sn[2*SPD_W-1 -: 2]};
        trial = {2'b00, p.sroot, 2'b01};
        r.sn = {p.sn[2*SPD_W-3:0], 2'b00};
        if (t >= trial) begin
            r.srem = (SPD_W+2)'(t - trial);
            r.sroot = {p.sroot[SPD_W-2:0], 1'b1};
        end else begin
            r.srem = t[SPD_W+1:0];
            r.sroot = {p.sroot[SPD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic item_t f_dev_step(input item_t p);
        item_t            r;
        logic [DEV_W+3:0] t;
        logic [DEV_W+3:0] trial;
        r = p;
        t = {p.trem, p.tn[2*DEV_W-1 -: 2]};
        trial = {2'b00, p.troot, 2'b01};
        r.tn = {p.tn[2*DEV_W-3:0], 2'b00};
        if (t >= trial) begin
            r.trem = (DEV_W+2)'(t - trial);
            r.troot = {p.troot[DEV_W-2:0], 1'b1};
        end else begin
            r.trem = t[DEV_W+1:0];
            r.troot = {p.troot[DEV_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring step of the projected-variance division, one quotient bit.
    function automatic item_t f_div_step(input item_t p);
        item_t        r;
        logic [DEN_W:0] t;
        r = p;
        t = {p.drem, p.dnum[QUO_W-1]};
        r.dnum = {p.dnum[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, p.den}) begin
            r.drem = DEN_W'(t - {1'b0, p.den});
            r.dq = {p.dq[QUO_W-2:0], 1'b1};
        end else begin
            r.drem = t[DEN_W-1:0];
            r.dq = {p.dq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic item_t f_gain_step(input item_t p);
        item_t             r;
        logic [GREM_W:0]   t;
        logic [GREM_W:0]   lim;
        r = p;
        t = {p.grem, 1'b0};
        lim = (GREM_W+1)'(p.limit[DEV_W:0]);
        if (t >= lim) begin
            r.grem = GREM_W'(t - lim);
            r.gq = {p.gq[FRAC_BITS-2:0], 1'b1};
        end else begin
            r.grem = t[GREM_W-1:0];
            r.gq = {p.gq[FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic item_t f_stage(input int idx, input item_t p, input logic [BUF_W-1:0] ub);
        item_t                 r;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] n2;
        logic [NUM_W-2:0]      nn;
        logic [SPD_W:0]        spd;
        logic [SPD_W:0]        lim;
        logic [VEL_W:0]        rx;
        logic [VEL_W:0]        ry;
        r = p;
        num = '0;
        n2 = '0;
        nn = '0;
        spd = '0;
        lim = '0;
        rx = '0;
        ry = '0;
        if (idx == ST_ABS) begin
            r = f_abs(p);
        end else if (idx == ST_MUL1) begin
            r.sqx = p.ax * p.ax;
            r.sqy = p.ay * p.ay;
            r.a = p.axs * p.axs;
            r.b = p.ays * p.ays;
            r.c = p.axs * p.ays;
        end else if (idx == ST_MUL2) begin
            r.ssum = (2*VEL_W+1)'(p.sqx) + (2*VEL_W+1)'(p.sqy);
            r.pa = (SQ_W+VAR_W)'(p.a) * (SQ_W+VAR_W)'(p.sxx);
            r.pb = (SQ_W+VAR_W)'(p.b) * (SQ_W+VAR_W)'(p.syy);
            r.pc = $signed({1'b0, p.c}) * p.sxy;
            r.den = DEN_W'(p.a) + DEN_W'(p.b);
        end else if (idx == ST_NUM) begin
            num = $signed(NUM_W'(p.pa)) + $signed(NUM_W'(p.pb));
            n2 = {p.pc[SQ_W+COV_W-1], p.pc, 1'b0};
            num = p.opp ? num - n2 : num + n2;
            nn = (num > 0) ? num[NUM_W-2:0] : '0;
            r.dnum = nn[QUO_W-1:0];
            r.drem = DEN_W'(nn[NUM_W-2:QUO_W]);
            r.dq = '0;
            r.sn = (2*SPD_W)'(p.ssum);
            r.srem = '0;
            r.sroot = '0;
        end else if (idx >= ST_D0 && idx < ST_TINIT) begin
            r = f_spd_step(f_div_step(p));
        end else if (idx == ST_TINIT) begin
            r.tn = (2*DEV_W)'({p.dq, {FRAC_BITS{1'b0}}});
            r.trem = '0;
            r.troot = '0;
        end else if (idx >= ST_T0 && idx < ST_LIM) begin
            r = f_dev_step(p);
        end else if (idx == ST_LIM) begin
            r.limit = $signed(VEL_W'(p.troot)) - $signed(VEL_W'(ub));
            r.trusted = p.limit[VEL_W-1] || (r.limit == '0) || r.limit[VEL_W-1];
            spd = (SPD_W+1)'(p.sroot);
            lim = (SPD_W+1)'(r.limit[DEV_W:0]);
            r.gz = spd <= lim;
            r.gf = spd >= {lim[SPD_W-1:0], 1'b0};
            r.grem = (r.gz || r.gf) ? '0 : GREM_W'(spd - lim);
            r.gq = '0;
        end else if (idx >= ST_G0 && idx < ST_GSEL) begin
            r = f_gain_step(p);
        end else if (idx == ST_GSEL) begin
            if (p.gz) begin
                r.gain = '0;
            end else if (p.gf) begin
                r.gain = GAIN_W'(1) << FRAC_BITS;
            end else begin
                r.gain = {1'b0, p.gq};
            end
        end else if (idx == ST_SCL) begin
            r.px = PROD_W'(p.ax) * PROD_W'(p.gain);
            r.py = PROD_W'(p.ay) * PROD_W'(p.gain);
        end else if (idx == ST_OUT) begin
            rx = p.px[FRAC_BITS +: VEL_W+1];
            ry = p.py[FRAC_BITS +: VEL_W+1];
            if (p.zero) begin
                r.ovx = p.vx;
                r.ovy = p.vy;
                r.verdict = VERDICT_ZERO;
            end else if (p.trusted) begin
                r.ovx = p.vx;
                r.ovy = p.vy;
                r.verdict = VERDICT_TRUSTED;
            end else begin
                r.ovx = p.vx[VEL_W-1] ? VEL_W'(-rx) : VEL_W'(rx);
                r.ovy = p.vy[VEL_W-1] ? VEL_W'(-ry) : VEL_W'(ry);
                r.verdict = VERDICT_GAIN;
            end
        end
        return r;
    endfunction

    // The pipeline moves as one unit unless a finished item is waiting at the output.
    assign adv = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign cfg_ready = 1'b1;

    always_comb begin
        pipe_next[ST_IN] = '0;
        pipe_next[ST_IN].vx = $signed(s_tdata[23:0]);
        pipe_next[ST_IN].vy = $signed(s_tdata[47:24]);
        pipe_next[ST_IN].sxx = s_tdata[70:48];
        pipe_next[ST_IN].syy = s_tdata[93:71];
        pipe_next[ST_IN].sxy = $signed(s_tdata[117:94]);
        for (int i = 1; i < NST; i++) begin
            pipe_next[i] = f_stage(i, pipe_reg[i-1], buf_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg <= pipe_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= BUF_RESET;
        end else if (cfg_valid) begin
            buf_reg <= cfg_data;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata = {pipe_reg[NST-1].ovy, pipe_reg[NST-1].ovx};
    assign m_tuser = pipe_reg[NST-1].verdict;

endmodule
`default_nettype wire
